// ===== hw/rtl/rect_overlap_max_component_area_macros.svh =====
// Assertion helpers for the rectangle grouping block.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef RECT_OVERLAP_MAX_COMPONENT_AREA_MACROS_SVH
`define RECT_OVERLAP_MAX_COMPONENT_AREA_MACROS_SVH
`ifndef SYNTHESIS
`define ROVA_CHECK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("rova check failed");
`define ROVA_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("rova forbidden condition");
`else
`define ROVA_CHECK(lbl, prop)
`define ROVA_NEVER(lbl, expr)
`endif
`endif

// ===== hw/rtl/rova_pkg.sv =====
`default_nettype none
package rova_pkg;
	localparam int DEF_MAX_RECTS = 1024;
	localparam int COORD_W       = 16;
	localparam int AREA_W        = 48;
	localparam int OUT_W         = 42;

	// one command per controller step
	typedef struct packed {
		logic capture;
		logic load;
		logic p1_rd;
		logic p1_chk;
		logic p1_acc;
		logic fin;
		logic p2_rd;
		logic p2_mk;
		logic p2_wr;
		logic bump;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic n_zero;
		logic last_j;
		logic last_item;
		logic out_busy;
	} sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/rova_ctrl.sv =====
`default_nettype none
module rova_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  rova_pkg::sts_t  sts,
	output rova_pkg::cmd_t  cmd
);
	import rova_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_P1RD, S_P1CHK, S_P1ACC, S_FIN,
		S_P2RD, S_P2MK, S_P2WR, S_POST, S_DONE
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.capture = (state_q == S_IDLE) && in_valid;
		cmd.load    = (state_q == S_LOAD);
		cmd.p1_rd   = (state_q == S_P1RD);
		cmd.p1_chk  = (state_q == S_P1CHK);
		cmd.p1_acc  = (state_q == S_P1ACC);
		cmd.fin     = (state_q == S_FIN);
		cmd.p2_rd   = (state_q == S_P2RD);
		cmd.p2_mk   = (state_q == S_P2MK);
		cmd.p2_wr   = (state_q == S_P2WR);
		cmd.bump    = (state_q == S_POST);
		cmd.emit    = (state_q == S_DONE) && !sts.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= sts.full ? S_POST : S_LOAD;
				end
				S_LOAD:  state_q <= sts.n_zero ? S_FIN : S_P1RD;
				S_P1RD:  state_q <= S_P1CHK;
				S_P1CHK: state_q <= S_P1ACC;
				S_P1ACC: state_q <= sts.last_j ? S_FIN : S_P1RD;
				S_FIN:   state_q <= sts.n_zero ? S_POST : S_P2RD;
				S_P2RD:  state_q <= S_P2MK;
				S_P2MK:  state_q <= S_P2WR;
				S_P2WR:  state_q <= sts.last_j ? S_POST : S_P2RD;
				S_POST:  state_q <= sts.last_item ? S_DONE : S_IDLE;
				S_DONE: begin
					if (!sts.out_busy)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/rova_dp.sv =====
`include "rect_overlap_max_component_area_macros.svh"
`default_nettype none
module rova_dp #(
	parameter int MAX_RECTS = rova_pkg::DEF_MAX_RECTS
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  rova_pkg::cmd_t                    cmd,
	output rova_pkg::sts_t                    sts,
	input  wire  [rova_pkg::COORD_W-1:0]      pos_x,
	input  wire  [rova_pkg::COORD_W-1:0]      pos_y,
	input  wire  [rova_pkg::COORD_W-1:0]      extent_w,
	input  wire  [rova_pkg::COORD_W-1:0]      extent_h,
	input  wire                               is_last,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [rova_pkg::OUT_W-1:0]        best_area,
	output logic                              overflowed
);
	import rova_pkg::*;

	localparam int IW = $clog2(MAX_RECTS);
	localparam int CW = $clog2(MAX_RECTS + 1);

	logic [COORD_W-1:0] x_q, y_q, w_q, h_q;
	logic               last_q;
	logic [CW-1:0]      count_q;
	logic [IW-1:0]      j_q;
	logic [AREA_W-1:0]  acc_q, best_q;
	logic               over_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   best_area_q;
	logic               overflowed_q;

	logic [4*COORD_W-1:0] rect_mem [MAX_RECTS];
	logic [IW-1:0]        comp_mem [MAX_RECTS];
	logic [IW-1:0]        mark_mem [MAX_RECTS];
	logic [AREA_W-1:0]    area_mem [MAX_RECTS];

	logic [4*COORD_W-1:0] rect_rd_q;
	logic [IW-1:0]        comp_rd_q, mark_rd_q;
	logic [AREA_W-1:0]    area_rd_q;
	logic                 meets_q;

	logic [IW-1:0]        n;
	logic [COORD_W-1:0]   rx, ry, rw, rh;
	logic [COORD_W:0]     lo_x, hi_x, lo_y, hi_y, ax, bx, ay, by;
	logic                 meets;
	logic [2*COORD_W-1:0] area_prod;

	assign n  = count_q[IW-1:0];
	assign rx = rect_rd_q[COORD_W-1:0];
	assign ry = rect_rd_q[2*COORD_W-1:COORD_W];
	assign rw = rect_rd_q[3*COORD_W-1:2*COORD_W];
	assign rh = rect_rd_q[4*COORD_W-1:3*COORD_W];

	// full 32-bit area of the captured rectangle
	assign area_prod = w_q * h_q;

	// closed-interval overlap on both axes
	always_comb begin
		ax   = {1'b0, x_q} + {1'b0, w_q};
		bx   = {1'b0, rx} + {1'b0, rw};
		ay   = {1'b0, y_q} + {1'b0, h_q};
		by   = {1'b0, ry} + {1'b0, rh};
		lo_x = (x_q > rx) ? {1'b0, x_q} : {1'b0, rx};
		hi_x = (ax < bx) ? ax : bx;
		lo_y = (y_q > ry) ? {1'b0, y_q} : {1'b0, ry};
		hi_y = (ay < by) ? ay : by;
		meets = (lo_x <= hi_x) && (lo_y <= hi_y);
	end

	assign sts.full      = (count_q == CW'(MAX_RECTS));
	assign sts.n_zero    = (count_q == '0);
	assign sts.last_j    = (j_q == IW'(count_q - 1'b1));
	assign sts.last_item = last_q;
	assign sts.out_busy  = out_valid_q;

	assign out_valid  = out_valid_q;
	assign best_area  = best_area_q;
	assign overflowed = overflowed_q;

	// memories
	always_ff @(posedge clk) begin
		if (cmd.load)
			rect_mem[n] <= {h_q, w_q, y_q, x_q};
		if (cmd.p1_rd)
			rect_rd_q <= rect_mem[j_q];

		if (cmd.load)
			comp_mem[n] <= n;
		else if (cmd.p2_wr && mark_rd_q == n)
			comp_mem[j_q] <= n;
		if (cmd.p1_rd || cmd.p2_rd)
			comp_rd_q <= comp_mem[j_q];

		if (cmd.load)
			mark_mem[n] <= n;
		else if (cmd.p1_acc && meets_q && mark_rd_q != n)
			mark_mem[comp_rd_q] <= n;
		if (cmd.p1_chk || cmd.p2_mk)
			mark_rd_q <= mark_mem[comp_rd_q];

		if (cmd.fin)
			area_mem[n] <= acc_q;
		if (cmd.p1_chk)
			area_rd_q <= area_mem[comp_rd_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q    <= pos_x;
			y_q    <= pos_y;
			w_q    <= extent_w;
			h_q    <= extent_h;
			last_q <= is_last;
		end
		if (cmd.p1_chk)
			meets_q <= meets;
		if (cmd.load)
			acc_q <= {{(AREA_W-2*COORD_W){1'b0}}, area_prod};
		else if (cmd.p1_acc && meets_q && mark_rd_q != n)
			acc_q <= acc_q + area_rd_q;
		if (cmd.load || cmd.fin)
			j_q <= '0;
		else if (cmd.p1_acc || cmd.p2_wr)
			j_q <= j_q + 1'b1;
		if (cmd.emit) begin
			best_area_q  <= best_q[OUT_W-1:0];
			overflowed_q <= over_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			best_q      <= '0;
			over_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture && sts.full)
				over_q <= 1'b1;
			if (cmd.fin && acc_q > best_q)
				best_q <= acc_q;
			if (cmd.bump && !sts.full)
				count_q <= count_q + 1'b1;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				count_q     <= '0;
				best_q      <= '0;
				over_q      <= 1'b0;
			end
		end
	end

	`ROVA_NEVER(a_count_range, count_q > CW'(MAX_RECTS))
	`ROVA_CHECK(a_emit_free, cmd.emit |-> !out_valid_q)
	`ROVA_CHECK(a_scan_range, (cmd.p1_rd || cmd.p2_rd) |-> (CW'(j_q) < count_q))
	`ROVA_CHECK(a_emit_clears, cmd.emit |=> (count_q == '0) && (best_q == '0))
endmodule
`default_nettype wire

// ===== hw/rtl/rect_overlap_max_component_area.sv =====
// Rectangle grouping engine. Items are axis-aligned rectangles (pos_x, pos_y,
// extent_w, extent_h); two rectangles belong to one group when their closed x
// and y ranges both intersect, so shared edges and corners count. The item
// with is_last set closes the set: one result follows with best_area, the
// largest summed width*height of any group, and overflowed, set when more
// than MAX_RECTS rectangles arrived (extras are dropped, the result still
// covers the stored ones). The block then starts a fresh set; no clearing
// pass is needed after reset or between sets.
// Rate: one item at a time. For each stored rectangle of a set, every
// earlier rectangle is visited twice, once to test overlap and gather the
// groups it meets, once to relabel members of those groups, and each visit
// is three steps through single-port memories (rectangle/label read, group
// mark read, update). A dropped item skips both passes. The closing item
// also moves its result into the output register. A finished result sits
// in that register, so the next item is taken while it waits; only a second
// result waits for the first to leave.
`default_nettype none
module rect_overlap_max_component_area #(
	parameter int MAX_RECTS = rova_pkg::DEF_MAX_RECTS
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [rova_pkg::COORD_W-1:0] pos_x,
	input  wire  [rova_pkg::COORD_W-1:0] pos_y,
	input  wire  [rova_pkg::COORD_W-1:0] extent_w,
	input  wire  [rova_pkg::COORD_W-1:0] extent_h,
	input  wire                          is_last,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [rova_pkg::OUT_W-1:0]   best_area,
	output logic                         overflowed
);
	import rova_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: accept, load, overlap pass, group close, relabel pass, result
	rova_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// rectangle, label, mark and group area stores plus accumulators
	rova_dp #(
		.MAX_RECTS (MAX_RECTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.extent_w   (extent_w),
		.extent_h   (extent_h),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.best_area  (best_area),
		.overflowed (overflowed)
	);
endmodule
`default_nettype wire
